/* hw/rtl/pmf_pkg.sv */
// ============================================================================
// pmf_pkg
// Shared widths, register indexes and types of the pattern mask filter.
// ============================================================================
package pmf_pkg;

    localparam int BYTE_W      = 8;
    localparam int PAT_W       = 64;
    localparam int LEN_CFG_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 1;
    localparam int MAX_PAT_DEF = 8;

    localparam logic [BYTE_W-1:0] STAR_CHAR = 8'd42;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 1'b1;

    // per-cell control from the filter unit
    typedef struct packed {
        logic shift;
        logic set_star;
    } t_cell_ctl;

    // one result word
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } t_out_word;

endpackage

/* hw/rtl/pmf_in_if.sv */
// ============================================================================
// pmf_in_if
// Input byte channel: valid/ready handshake with text byte and end flag.
// ============================================================================
interface pmf_in_if;
    logic                      valid;
    logic                      ready;
    logic [pmf_pkg::BYTE_W-1:0] data_byte;
    logic                      end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

/* hw/rtl/pmf_out_if.sv */
// ============================================================================
// pmf_out_if
// Output byte channel: valid/ready handshake with filtered byte and last flag.
// ============================================================================
interface pmf_out_if;
    logic                      valid;
    logic                      ready;
    logic [pmf_pkg::BYTE_W-1:0] out_byte;
    logic                      out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* hw/rtl/pmf_cell.sv */
// ============================================================================
// pmf_cell
// One window slot: holds a byte and its star mark, takes its neighbor's slot
// on a shift and compares the shifted-in byte with its pattern byte.
// ============================================================================
module pmf_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pmf_pkg::t_cell_ctl         i_ctl,
    input  logic [pmf_pkg::BYTE_W-1:0] i_byte,
    input  logic                       i_star,
    input  logic [pmf_pkg::BYTE_W-1:0] i_pat,
    output logic [pmf_pkg::BYTE_W-1:0] o_byte,
    output logic                       o_star,
    output logic [pmf_pkg::BYTE_W-1:0] o_nx_byte,
    output logic                       o_nx_star,
    output logic                       o_match
);

    logic [pmf_pkg::BYTE_W-1:0] r_byte;
    logic                       r_star;
    logic [pmf_pkg::BYTE_W-1:0] w_sh_byte;
    logic                       w_sh_star;
    logic [pmf_pkg::BYTE_W-1:0] n_byte;
    logic                       n_star;

    // view of the slot after this cycle's shift, before starring
    assign w_sh_byte = i_ctl.shift ? i_byte : r_byte;
    assign w_sh_star = i_ctl.shift ? i_star : r_star;

    assign o_match = (w_sh_byte == i_pat) && !w_sh_star;

    assign n_byte = w_sh_byte;
    assign n_star = w_sh_star | i_ctl.set_star;

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        if (!i_rst_n) begin
            r_star <= 1'b0;
        end else begin
            r_star <= n_star;
        end
    end

    assign o_byte    = r_byte;
    assign o_star    = r_star;
    assign o_nx_byte = n_byte;
    assign o_nx_star = n_star;

endmodule

/* hw/rtl/pmf_out_queue.sv */
// ============================================================================
// pmf_out_queue
// Two-entry output queue that decouples the window from the output stall.
// ============================================================================
module pmf_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pmf_pkg::t_out_word i_word,
    output logic               o_free,
    pmf_out_if.source          o_out
);

    pmf_pkg::t_out_word r_q [2];
    logic               r_head;
    logic [1:0]         r_cnt;
    logic               n_head;
    logic [1:0]         n_cnt;
    logic               w_pop;
    logic               w_wr_idx;

    assign w_pop    = o_out.valid && o_out.ready;
    assign w_wr_idx = r_head ^ r_cnt[0];
    assign o_free   = (r_cnt != 2'd2);

    always_comb begin
        n_head = r_head ^ w_pop;
        n_cnt  = r_cnt + {1'b0, i_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[w_wr_idx] <= i_word;
        end
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_head <= n_head;
            r_cnt  <= n_cnt;
        end
    end

    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_q[r_head].out_byte;
    assign o_out.out_last = r_q[r_head].out_last;

endmodule

/* hw/rtl/pattern_mask_filter_unit.sv */
// ============================================================================
// pattern_mask_filter_unit
// Byte-stream censor: every leftmost, non-overlapping occurrence of the
// configured pattern is replaced by asterisks.
// ============================================================================
// Usage:
//   i_in carries text words (data_byte, end_of_text), o_out carries filtered
//   words (out_byte, out_last). Both are valid/ready channels.
//   The pattern (i_cfg_idx 0, eight bytes, byte 0 low) and its length
//   (i_cfg_idx 1, 1..MAX_PAT) are written through i_cfg_we while idle.
//   The window is a row of MAX_PAT cells; every accepted word shifts in at
//   the newest cell and all cells compare against the pattern in parallel.
//   Throughput: one word per cycle unless draining or the queue is full. A word
//   leaves once the window holds pattern length bytes, so output lags input by
//   pattern length minus one words; words then pass the two-entry output queue.
//   A word with end_of_text drains the window: one word per cycle while the
//   queue has room, until all it holds (up to MAX_PAT) is out; input is held
//   off meanwhile, and the final word carries out_last.
//   When o_out stalls the queue fills and input ready drops; nothing is lost.
//   Reset empties the window and queue; pattern resets to zero, length to 1.
// ============================================================================
module pattern_mask_filter_unit #(
    parameter int MAX_PAT = pmf_pkg::MAX_PAT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pmf_in_if.sink                         i_in,
    pmf_out_if.source                      o_out
);

    localparam int CNT_W = $clog2(MAX_PAT + 1);
    localparam int IDX_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;
    localparam int BW    = pmf_pkg::BYTE_W;

    logic [pmf_pkg::PAT_W-1:0]     r_pat;
    logic [pmf_pkg::LEN_CFG_W-1:0] r_len;
    logic [CNT_W-1:0]              r_fill;
    logic [CNT_W-1:0]              n_fill;
    logic                          r_drain;
    logic                          n_drain;

    logic [pmf_pkg::LEN_CFG_W-1:0] w_len4;
    logic [CNT_W-1:0]              w_len;
    logic [CNT_W-1:0]              w_fn;
    logic                          w_accept;
    logic                          w_free;
    logic                          w_hit;
    logic                          w_emit_norm;
    logic                          w_emit_drain;
    logic                          w_push;
    logic [IDX_W-1:0]              w_idx;
    pmf_pkg::t_out_word            w_word;

    logic [MAX_PAT-1:0][BW-1:0]    w_cb;
    logic [MAX_PAT-1:0]            w_cs;
    logic [MAX_PAT-1:0][BW-1:0]    w_nb;
    logic [MAX_PAT-1:0]            w_ns;
    logic [MAX_PAT-1:0]            w_match;
    logic [MAX_PAT-1:0]            w_ok;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= '0;
            r_len <= pmf_pkg::LEN_CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pmf_pkg::REG_PATTERN_BYTES: r_pat <= i_cfg_data;
                pmf_pkg::REG_PATTERN_LEN:   r_len <= i_cfg_data[pmf_pkg::LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero length acts as 1, oversize as MAX_PAT
    always_comb begin
        if (r_len == '0) begin
            w_len4 = pmf_pkg::LEN_CFG_W'(1);
        end else if (r_len > pmf_pkg::LEN_CFG_W'(MAX_PAT)) begin
            w_len4 = pmf_pkg::LEN_CFG_W'(MAX_PAT);
        end else begin
            w_len4 = r_len;
        end
    end
    assign w_len = CNT_W'(w_len4);

    assign i_in.ready = !r_drain && w_free;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_fn       = r_fill + CNT_W'(1);

    // cell 0 is the newest slot; it faces the last pattern byte
    genvar j;
    generate
        for (j = 0; j < MAX_PAT; j++) begin : g_cell
            logic [CNT_W-1:0]   w_pidx;
            logic [BW-1:0]      w_pat;
            logic [BW-1:0]      w_in_byte;
            logic               w_in_star;
            pmf_pkg::t_cell_ctl w_ctl;

            assign w_pidx = w_len - CNT_W'(j + 1);
            assign w_pat  = r_pat[w_pidx[IDX_W-1:0] * BW +: BW];

            if (j == 0) begin : g_head
                assign w_in_byte = i_in.data_byte;
                assign w_in_star = 1'b0;
            end else begin : g_link
                assign w_in_byte = w_cb[j-1];
                assign w_in_star = w_cs[j-1];
            end

            assign w_ok[j]        = (CNT_W'(j) >= w_len) || w_match[j];
            assign w_ctl.shift    = w_accept;
            assign w_ctl.set_star = w_hit && (CNT_W'(j) < w_len);

            pmf_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_byte    (w_in_byte),
                .i_star    (w_in_star),
                .i_pat     (w_pat),
                .o_byte    (w_cb[j]),
                .o_star    (w_cs[j]),
                .o_nx_byte (w_nb[j]),
                .o_nx_star (w_ns[j]),
                .o_match   (w_match[j])
            );
        end
    endgenerate

    assign w_hit        = w_accept && (w_fn >= w_len) && (&w_ok);
    assign w_emit_norm  = w_accept && !i_in.end_of_text && (w_fn >= w_len);
    assign w_emit_drain = r_drain && w_free;
    assign w_push       = w_emit_norm || w_emit_drain;

    // oldest slot sits at fill of the shifted view, or at fill-1 while draining
    assign w_idx = w_emit_norm ? r_fill[IDX_W-1:0] : IDX_W'(r_fill - CNT_W'(1));

    assign w_word.out_byte = w_ns[w_idx] ? pmf_pkg::STAR_CHAR : w_nb[w_idx];
    assign w_word.out_last = w_emit_drain && (r_fill == CNT_W'(1));

    always_comb begin
        n_fill  = r_fill;
        n_drain = r_drain;
        if (w_accept) begin
            if (i_in.end_of_text) begin
                n_fill  = w_fn;
                n_drain = 1'b1;
            end else if (w_fn < w_len) begin
                n_fill = w_fn;
            end
        end else if (w_emit_drain) begin
            n_fill = r_fill - CNT_W'(1);
            if (r_fill == CNT_W'(1)) begin
                n_drain = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_drain <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_drain <= n_drain;
        end
    end

    pmf_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_word),
        .o_free  (w_free),
        .o_out   (o_out)
    );

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drain |-> (r_fill < CNT_W'(MAX_PAT)))
        else $error("window fill out of range while streaming");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drain |-> (r_fill != '0))
        else $error("drain with empty window");

    a_last_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_word.out_last) |-> r_drain)
        else $error("last word outside drain");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_word.out_last) |=> (!r_drain && (r_fill == '0)))
        else $error("drain did not end after last word");

    a_hit_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hit |-> (w_fn >= w_len) && !r_drain)
        else $error("pattern hit without a full window");
`endif

endmodule

/* tb/sv/pmf_mask_checker.sv */
// ============================================================================
// pmf_mask_checker
// Watches the register port and both word channels of the pattern mask
// filter, predicts each filtered word and compares it with what comes out.
// ============================================================================
module pmf_mask_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pmf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pmf_in_if                              in_ch,
    pmf_out_if                             out_ch,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [pmf_pkg::PAT_W-1:0]     pattern_q;
    logic [pmf_pkg::LEN_CFG_W-1:0] len_q;
    logic [pmf_pkg::BYTE_W-1:0]    window_q [pmf_pkg::MAX_PAT_DEF];
    bit                            starred_q [pmf_pkg::MAX_PAT_DEF];
    int                            fill;
    pmf_pkg::t_out_word            masked_words_due [$];

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        o_fail_count++;
    endtask

    // zero acts as one, anything past the window acts as a full window
    function automatic int active_len();
        int n;
        n = int'(len_q);
        if (n == 0) begin
            n = 1;
        end
        if (n > pmf_pkg::MAX_PAT_DEF) begin
            n = pmf_pkg::MAX_PAT_DEF;
        end
        return n;
    endfunction

    task automatic release_oldest(input bit last);
        pmf_pkg::t_out_word w;
        w.out_byte = starred_q[0] ? pmf_pkg::STAR_CHAR : window_q[0];
        w.out_last = last;
        masked_words_due.push_back(w);
        for (int i = 0; i < pmf_pkg::MAX_PAT_DEF - 1; i++) begin
            window_q[i]  = window_q[i+1];
            starred_q[i] = starred_q[i+1];
        end
        window_q[pmf_pkg::MAX_PAT_DEF-1]  = '0;
        starred_q[pmf_pkg::MAX_PAT_DEF-1] = 1'b0;
        if (fill > 0) begin
            fill--;
        end
    endtask

    task automatic censor_byte(input logic [pmf_pkg::BYTE_W-1:0] b, input logic eot);
        int len;
        int base;
        bit hit;
        len = active_len();
        if (fill > pmf_pkg::MAX_PAT_DEF - 1) begin
            fill = pmf_pkg::MAX_PAT_DEF - 1;
        end
        window_q[fill]  = b;
        starred_q[fill] = 1'b0;
        fill++;
        // compare the newest len slots; a slot already starred blocks a match
        if (fill >= len) begin
            base = fill - len;
            hit  = 1'b1;
            for (int i = 0; i < len; i++) begin
                if (starred_q[base+i] || window_q[base+i] != pattern_q[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                for (int i = 0; i < len; i++) begin
                    starred_q[base+i] = 1'b1;
                end
            end
        end
        if (eot) begin
            while (fill > 0) begin
                release_oldest(fill == 1);
            end
            foreach (window_q[i]) begin
                window_q[i]  = '0;
                starred_q[i] = 1'b0;
            end
        end else if (fill >= len) begin
            release_oldest(1'b0);
        end
    endtask

    always @(posedge i_clk) begin
        pmf_pkg::t_out_word want;
        if (!i_rst_n) begin
            pattern_q    = '0;
            len_q        = pmf_pkg::LEN_CFG_W'(1);
            fill         = 0;
            o_fail_count = 0;
            foreach (window_q[i]) begin
                window_q[i]  = '0;
                starred_q[i] = 1'b0;
            end
            masked_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pmf_pkg::REG_PATTERN_BYTES) begin
                    pattern_q = i_cfg_data[pmf_pkg::PAT_W-1:0];
                end else if (i_cfg_idx == pmf_pkg::REG_PATTERN_LEN) begin
                    len_q = i_cfg_data[pmf_pkg::LEN_CFG_W-1:0];
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                censor_byte(in_ch.data_byte, in_ch.end_of_text);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (masked_words_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word %h last %b",
                                            out_ch.out_byte, out_ch.out_last));
                end else begin
                    want = masked_words_due.pop_front();
                    if (out_ch.out_byte !== want.out_byte) begin
                        flag_mismatch($sformatf("out_byte %h, want %h",
                                                out_ch.out_byte, want.out_byte));
                    end
                    if (out_ch.out_last !== want.out_last) begin
                        flag_mismatch($sformatf("out_last %b, want %b",
                                                out_ch.out_last, want.out_last));
                    end
                end
            end
        end
        o_pending = masked_words_due.size();
    end

endmodule

/* tb/sv/tb_pattern_mask_filter_unit.sv */
// ============================================================================
// tb_pattern_mask_filter_unit
// Drives text words and pattern settings into the filter with random gaps
// and stalls on both channels; the checker beside it predicts and compares.
// ============================================================================
module tb_pattern_mask_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;
    localparam int SETTLE     = 20;
    localparam int HOLD_LEN   = 150;
    localparam int WORD_GOAL  = 300;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [pmf_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [pmf_pkg::CFG_DATA_W-1:0] cfg_data;

    int send_mode  = 0;
    int rcv_mode   = 0;
    int hold_req   = 0;
    int hold_seen  = 0;
    int words_sent = 0;
    int idle_cycles = 0;
    int fail_count;
    int pending;

    pmf_in_if  in_ch ();
    pmf_out_if out_ch ();

    pattern_mask_filter_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    pmf_mask_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 clk = ~clk;

    // mode 0: back to back, 1: random gaps, 2: an occasional gap
    function automatic int draw_gap(input int mode);
        if (mode == 1) begin
            return $urandom_range(0, 19);
        end else if (mode == 2) begin
            return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        end
        return 0;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eot);
        int gap;
        gap = draw_gap(send_mode);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.data_byte   <= b;
        in_ch.end_of_text <= eot;
        do @(posedge clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic send_str(input string s, input bit with_end);
        for (int i = 0; i < s.len(); i++) begin
            send_word(s[i], with_end && (i == s.len() - 1));
        end
    endtask

    // settings change only once every predicted word is out and the block is quiet
    task automatic reconfigure(input logic [63:0] pat, input logic [63:0] len_data);
        in_ch.valid <= 1'b0;
        // let the checker see the last accepted word first
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= pmf_pkg::REG_PATTERN_BYTES;
        cfg_data <= pat;
        @(posedge clk);
        cfg_idx  <= pmf_pkg::REG_PATTERN_LEN;
        cfg_data <= len_data;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_req != hold_seen) begin
                gap = HOLD_LEN;
                hold_seen++;
            end else begin
                gap = draw_gap(rcv_mode);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [63:0] pat;
        logic [63:0] len_data;
        logic [7:0]  text [$];
        int          plen;
        int          nstreams;
        int          tlen;
        int          r;
        bit          with_end;
        bit          open_stream;
        bit          first_phase;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = pmf_pkg::REG_PATTERN_BYTES;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.data_byte   = '0;
        in_ch.end_of_text = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: pattern of one zero byte
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);

        // overlapping candidates, only the leftmost one is masked
        reconfigure(64'h6161, 64'd2);
        send_str("aaa", 1'b1);

        // zero length acts as one
        reconfigure(64'h5A, 64'd0);
        send_str("ZqZ", 1'b1);

        // oversize length acts as a full window
        pat = 64'h7F80_01FE_00FF_55AA;
        reconfigure(pat, 64'd15);
        for (int i = 0; i < 8; i++) begin
            send_word(pat[8*i +: 8], i == 7);
        end

        // shrink the length while the window still holds bytes
        reconfigure(64'h7A7978, 64'd3);
        send_str("ab", 1'b0);
        reconfigure(64'h7A7978, 64'd1);
        send_str("xc", 1'b1);

        // stray upper bits in the length word; a one-word stream
        reconfigure(64'h7A7978, 64'hFFFF_FFFF_FFFF_FFF1);
        send_word("x", 1'b1);

        first_phase = 1'b1;
        open_stream = 1'b0;
        while (words_sent < WORD_GOAL) begin
            len_data = {$urandom, $urandom};
            if ($urandom_range(0, 3) != 0) begin
                len_data = '0;
            end
            len_data[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(1, 8));
            plen = (len_data[3:0] == 0) ? 1 : int'(len_data[3:0]);
            if (plen > pmf_pkg::MAX_PAT_DEF) begin
                plen = pmf_pkg::MAX_PAT_DEF;
            end
            for (int i = 0; i < 8; i++) begin
                pat[8*i +: 8] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'("a" + $urandom_range(0, 2));
            end
            reconfigure(pat, len_data);

            send_mode = $urandom_range(0, 2);
            rcv_mode  = $urandom_range(0, 2);
            if (first_phase) begin
                // receiver stops for a long stretch while words keep coming
                hold_req++;
                send_mode   = 0;
                first_phase = 1'b0;
            end

            nstreams = $urandom_range(1, 3);
            for (int s = 0; s < nstreams; s++) begin
                tlen = $urandom_range(1, 30);
                text.delete();
                while (text.size() < tlen) begin
                    r = $urandom_range(0, 9);
                    if (r < 4) begin
                        for (int k = 0; k < plen; k++) begin
                            text.push_back(pat[8*k +: 8]);
                        end
                    end else if (r < 8) begin
                        text.push_back(pat[8*$urandom_range(0, plen - 1) +: 8]);
                    end else begin
                        text.push_back(8'($urandom_range(0, 255)));
                    end
                end
                // the last stream may stay open across the next settings change
                with_end = (s < nstreams - 1) || ($urandom_range(0, 3) != 0);
                foreach (text[i]) begin
                    send_word(text[i], with_end && (i == text.size() - 1));
                end
                open_stream = !with_end;
            end
        end
        if (open_stream) begin
            send_word(8'($urandom_range(0, 255)), 1'b1);
        end

        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
